/* sv/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b at the same edge
`define ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// a implies b at the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

`endif

/* sv/aes_pkg.sv */
`timescale 1ns / 1ps
package aes_pkg;
   localparam logic [1:0] KEY_128 = 2'd0;
   localparam logic [1:0] KEY_192 = 2'd1;
   localparam logic [1:0] KEY_256 = 2'd2;
   localparam logic [2:0] CSR_KEY_LENGTH = 3'd0;
   localparam logic [2:0] CSR_KEY_0 = 3'd1;
   localparam logic [2:0] CSR_KEY_3 = 3'd4;
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   localparam logic [7:0] FWD_BOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_BOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic byte_type xtime(input byte_type a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {FWD_BOX[w[31:24]], FWD_BOX[w[23:16]], FWD_BOX[w[15:8]], FWD_BOX[w[7:0]]};
   endfunction

   // forward mix of one column, byte 0 in top bits
   function automatic logic [31:0] mix_col(input logic [31:0] c);
      byte_type a0, a1, a2, a3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                 a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                 a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                 xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // inverse mix as preconditioning then forward mix
   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      byte_type u, v;
      u = xtime(xtime(c[31:24] ^ c[15:8]));
      v = xtime(xtime(c[23:16] ^ c[7:0]));
      inv_mix_col = mix_col({c[31:24] ^ u, c[23:16] ^ v, c[15:8] ^ u, c[7:0] ^ v});
   endfunction
endpackage

/* sv/aes_block_cipher_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// AES-128/192/256 encrypt and decrypt, one 128-bit block per transaction. After reset or
// any csr write, the first block first expands the key schedule into a store of
// ROUND_KEY_WORDS words (60 by default), one word per cycle, then a fetch state reads the
// first round key back. Each block then passes a load state with the first key addition,
// the round state once per round through a single shared round unit that reads four
// round-key words from the store, and a done state that moves the result into the output
// register; the core then returns to idle and can take the next block. req_stall is high
// from acceptance until the result has moved into the output register, which waits while
// an earlier result is still stalled there, and during a csr write.
module aes_block_cipher_core
   import aes_pkg::*;
#(
   parameter int ROUND_KEY_WORDS = 60
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [63:0] req_block_hi,
   input  logic [63:0] req_block_lo,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_hi,
   output logic [63:0] rsp_result_lo,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   localparam int AW = $clog2(ROUND_KEY_WORDS);
   localparam int RW = $clog2(ROUND_KEY_WORDS / 4);
   // largest key the store holds
   localparam logic [1:0] MAX_LEN = (ROUND_KEY_WORDS >= 60) ? KEY_256 :
                                    (ROUND_KEY_WORDS >= 52) ? KEY_192 : KEY_128;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXPAND = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;
   localparam logic [2:0] ST_FETCH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] klen_ff;
   logic [63:0] key_ff [4];
   logic ready_ff, ready_in;
   logic [3:0] nk_ff;
   logic [3:0] nr_ff;
   logic [31:0] rk_mem [4][ROUND_KEY_WORDS/4];
   logic [AW-1:0] widx_ff, widx_in;
   logic [3:0] kcnt_ff, kcnt_in;
   logic [7:0] rcon_ff, rcon_in;
   logic [31:0] hist_ff [8];
   logic [3:0] round_ff, round_in;
   logic cmd_ff;
   block_type blk_ff, blk_in;
   block_type rk_q;
   logic [RW-1:0] raddr;
   logic [127:0] data_ff;
   logic rsp_valid_ff;

   // effective key length
   logic [1:0] len_eff;
   logic [3:0] nk_eff;
   always_comb begin
      len_eff = (klen_ff == 2'd3) ? KEY_256 : klen_ff;
      if (len_eff > MAX_LEN) len_eff = MAX_LEN;
      nk_eff = 4'(4 + 2 * len_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= KEY_128;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
      end else if (csr_write) begin
         if (csr_index == CSR_KEY_LENGTH) klen_ff <= csr_data[1:0];
         else if (csr_index >= CSR_KEY_0 && csr_index <= CSR_KEY_3)
            key_ff[2'(csr_index - CSR_KEY_0)] <= csr_data;
      end
   end

   // key expansion word, hist_ff[0] is w[i-1], hist_ff[nk-1] is w[i-nk]
   logic [31:0] new_word, t;
   logic [AW:0] wtotal;
   always_comb begin
      t = hist_ff[0];
      if (kcnt_ff == 4'd0) t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
      else if (nk_ff > 4'd6 && kcnt_ff == 4'd4) t = sub_word(t);
      if (widx_ff < AW'(nk_ff)) begin
         new_word = widx_ff[0] ? key_ff[widx_ff[2:1]][31:0] : key_ff[widx_ff[2:1]][63:32];
      end else begin
         new_word = hist_ff[3'(nk_ff - 4'd1)] ^ t;
      end
      wtotal = (AW+1)'(4 * (nk_ff + 4'd7));
   end

   logic in_acc, out_acc;
   assign in_acc = req_valid && !req_stall;
   assign out_acc = rsp_valid_ff && !rsp_stall;
   assign req_stall = state_ff != ST_IDLE || csr_write;

   // round unit
   block_type ss, mx;
   logic [3:0] rnext;
   always_comb begin
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            ss[127-32*c-8*r -: 8] = cmd_ff ?
               INV_BOX[blk_ff[127-32*((c+4-r)%4)-8*r -: 8]] :
               FWD_BOX[blk_ff[127-32*((c+r)%4)-8*r -: 8]];
         end
      for (int c = 0; c < 4; c++) begin
         if (cmd_ff) mx[127-32*c -: 32] = inv_mix_col(ss[127-32*c -: 32] ^ rk_q[127-32*c -: 32]);
         else        mx[127-32*c -: 32] = mix_col(ss[127-32*c -: 32]) ^ rk_q[127-32*c -: 32];
      end
      rnext = cmd_ff ? round_ff - 4'd1 : round_ff + 4'd1;
   end

   logic last_round;
   assign last_round = cmd_ff ? (round_ff == 4'd0) : (round_ff == nr_ff);

   always_comb begin
      raddr = RW'(round_ff);
      if (state_ff == ST_IDLE) raddr = (req_cmd == CMD_DECRYPT) ? RW'(nr_ff) : '0;
      else if (state_ff == ST_LOAD || (state_ff == ST_ROUND && !last_round))
         raddr = RW'(rnext);
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) rk_q[127-32*c -: 32] <= rk_mem[c][raddr];
      if (state_ff == ST_EXPAND) rk_mem[widx_ff[1:0]][widx_ff[AW-1:2]] <= new_word;
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff && !csr_write;
      widx_in = widx_ff;
      kcnt_in = kcnt_ff;
      rcon_in = rcon_ff;
      round_in = round_ff;
      blk_in = blk_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_acc) begin
               if (ready_ff) begin
                  state_in = ST_LOAD;
                  round_in = (req_cmd == CMD_DECRYPT) ? nr_ff : 4'd0;
               end else begin
                  state_in = ST_EXPAND;
                  widx_in = '0;
                  kcnt_in = '0;
                  rcon_in = 8'h01;
               end
            end
         end
         ST_EXPAND: begin
            widx_in = widx_ff + 1'b1;
            if (widx_ff >= AW'(nk_ff)) begin
               kcnt_in = (kcnt_ff == nk_ff - 4'd1) ? 4'd0 : kcnt_ff + 4'd1;
               if (kcnt_ff == 4'd0) rcon_in = xtime(rcon_ff);
            end else if (widx_ff == AW'(nk_ff - 4'd1)) begin
               kcnt_in = '0;
            end
            if ({1'b0, widx_ff} == wtotal - 1'b1) begin
               state_in = ST_FETCH;
               ready_in = 1'b1;
               round_in = cmd_ff ? nr_ff : 4'd0;
            end
         end
         // the last schedule word lands in the store only now, read the first key here
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD: begin
            blk_in = blk_ff ^ rk_q;
            state_in = ST_ROUND;
            round_in = rnext;
         end
         ST_ROUND: begin
            if (last_round) begin
               blk_in = ss ^ rk_q;
               state_in = ST_DONE;
            end else begin
               blk_in = mx;
               round_in = rnext;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || out_acc) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (in_acc) blk_in = {req_block_hi, req_block_lo};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         if (state_ff == ST_DONE && (!rsp_valid_ff || out_acc)) rsp_valid_ff <= 1'b1;
         else if (out_acc) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      widx_ff <= widx_in;
      kcnt_ff <= kcnt_in;
      rcon_ff <= rcon_in;
      round_ff <= round_in;
      blk_ff <= blk_in;
      if (in_acc) cmd_ff <= req_cmd;
      if (state_ff == ST_DONE && (!rsp_valid_ff || out_acc)) data_ff <= blk_ff;
      if (in_acc && !ready_ff) begin
         nk_ff <= nk_eff;
         nr_ff <= nk_eff + 4'd6;
      end
      if (state_ff == ST_EXPAND) begin
         hist_ff[0] <= new_word;
         for (int i = 1; i < 8; i++) hist_ff[i] <= hist_ff[i-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_hi = data_ff[127:64];
   assign rsp_result_lo = data_ff[63:0];

   `ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, req_stall)
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, in_acc, state_ff == ST_LOAD || state_ff == ST_EXPAND)
   `ASSERT_IMP(a_fetch_after_ready, clock, reset, state_ff == ST_FETCH, ready_ff)
   `ASSERT_IMP(a_round_in_range, clock, reset, state_ff == ST_ROUND, round_ff <= nr_ff)
endmodule
